// ===== rtl/pppt_pkg.sv =====
// ----------------------------------------------------------------------------
// pppt_pkg
// Shared constants and arithmetic step functions of the pulse peak evaluator.
// ----------------------------------------------------------------------------
package pppt_pkg;

  localparam int unsigned AddrW     = 5;
  localparam int unsigned ShapeFrac = 16;
  localparam int unsigned QBits     = 60;
  localparam logic [63:0] QOne      = 64'h1000_0000_0000_0000;
  localparam logic [33:0] TermCap   = 34'h2_0000_0000;

  localparam logic [2:0] REG_AREA   = 3'd0;
  localparam logic [2:0] REG_CENTER = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SHAPE  = 3'd3;
  localparam logic [2:0] REG_BKGND  = 3'd4;

  typedef struct packed {
    logic         vld;
    logic         act;
    logic         uz;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  c;
    logic [63:0]  e;
    logic [63:0]  f;
    logic [255:0] pp;
    logic [255:0] pq;
  } st_t;

  function automatic logic [255:0] mul_pp(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] p00, p01, p10, p11;
    p00 = x[31:0] * y[31:0];
    p01 = x[31:0] * y[63:32];
    p10 = x[63:32] * y[31:0];
    p11 = x[63:32] * y[63:32];
    return {p11, p10, p01, p00};
  endfunction

  function automatic logic [127:0] pp_sum(input logic [255:0] pp);
    logic [127:0] s;
    s = {64'b0, pp[63:0]} + {32'b0, pp[127:64], 32'b0} + {32'b0, pp[191:128], 32'b0}
        + {pp[255:192], 64'b0};
    return s;
  endfunction

  function automatic logic [63:0] qsel(input logic [255:0] pp);
    logic [127:0] s;
    s = pp_sum(pp);
    return s[QBits+63:QBits];
  endfunction

  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic nb,
                                           input logic [63:0] dv);
    logic [63:0] r;
    logic        ge;
    r  = {rem[62:0], nb};
    ge = (r >= dv);
    return {ge, ge ? r - dv : r};
  endfunction

  function automatic logic [6:0] div_step_n(input logic [5:0] rem, input logic nb,
                                            input logic [4:0] dv);
    logic [5:0] r;
    logic       ge;
    r  = {rem[4:0], nb};
    ge = (r >= {1'b0, dv});
    return {ge, ge ? r - {1'b0, dv} : r};
  endfunction

  function automatic logic [127:0] sqrt_step(input logic [63:0] res, input logic [63:0] rem,
                                             input logic [1:0] pair);
    logic [63:0] r, t, q;
    r = {rem[61:0], pair};
    t = {res[61:0], 2'b01};
    if (r >= t) begin
      r = r - t;
      q = {res[62:0], 1'b1};
    end else begin
      q = {res[62:0], 1'b0};
    end
    return {q, r};
  endfunction

endpackage

// ===== rtl/pulse_peak_power_term_eval_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_peak_power_term_eval_unit
// Pipelined evaluator of an area-normalized pulse peak with a power term.
// ----------------------------------------------------------------------------
// The unit takes one abscissa word in every clock cycle and busy stays low.
// Each word goes through a fixed pipeline of 577 register stages, the output
// register included; its result is shown on the out_ ports, with out_strobe
// high, for one cycle. Results leave in order and cannot be held off. The
// depth is set by the bit-serial dividers, the 20-term exponential series
// and the sixteen chained square roots, each unrolled into stages.
// The user writes configuration through the APB port only while no word is
// in flight; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module pulse_peak_power_term_eval_unit
  import pppt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_abscissa,
  output logic               out_strobe,
  output logic signed [31:0] out_peak_value,
  output logic               out_saturated,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [31:0] AreaRst  = 32'(64'd1 << FRAC_BITS);
  localparam logic [30:0] WidthRst = 31'(64'd1 << FRAC_BITS);
  localparam int unsigned OutShift = 76 - FRAC_BITS;

  localparam int unsigned ZSt    = 19;
  localparam int unsigned NTerm  = 20;
  localparam int unsigned TermSt = 10;
  localparam int unsigned NSq    = 6;
  localparam int unsigned PBits  = 8;
  localparam int unsigned RootSt = 16;
  localparam int unsigned RtGrp  = RootSt + 2;
  localparam int unsigned WSt    = 32;

  localparam int unsigned OZdiv = 2;
  localparam int unsigned OW    = OZdiv + ZSt;
  localparam int unsigned OSer  = OW + 1;
  localparam int unsigned OSq   = OSer + NTerm * TermSt;
  localparam int unsigned OU    = OSq + 2 * NSq;
  localparam int unsigned OPow  = OU + 1;
  localparam int unsigned ORt   = OPow + 2 * PBits;
  localparam int unsigned OG    = ORt + ShapeFrac * RtGrp;
  localparam int unsigned OAm   = OG + 2;
  localparam int unsigned OPk   = OAm + 1;
  localparam int unsigned OWd   = OPk + 2;
  localparam int unsigned OFin  = OWd + WSt;

  logic signed [31:0] area_r, center_r, bkgnd_r;
  logic [30:0]        width_r;
  logic [23:0]        shape_r;
  logic               cfg_wr;
  logic [63:0]        wdv;
  logic [23:0]        shv;

  st_t pipe_r [1:OFin];

  logic               out_strobe_r;
  logic signed [31:0] out_peak_value_r;
  logic               out_saturated_r;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r   <= AreaRst;
      center_r <= '0;
      width_r  <= WidthRst;
      shape_r  <= 24'h01_0000;
      bkgnd_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_AREA:   area_r   <= pwdata;
        REG_CENTER: center_r <= pwdata;
        REG_WIDTH:  width_r  <= pwdata[30:0];
        REG_SHAPE:  shape_r  <= pwdata[23:0];
        REG_BKGND:  bkgnd_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_AREA:   prdata = area_r;
      REG_CENTER: prdata = center_r;
      REG_WIDTH:  prdata = {1'b0, width_r};
      REG_SHAPE:  prdata = {8'b0, shape_r};
      REG_BKGND:  prdata = bkgnd_r;
      default:    prdata = '0;
    endcase
  end

  assign wdv  = {33'b0, (width_r == '0) ? 31'd1 : width_r};
  assign shv  = (shape_r == '0) ? 24'd1 : shape_r;
  assign busy = 1'b0;

  // Stage 0: offset from the peak onset
  st_t s0_nx;
  logic [32:0] s0_d;
  always_comb begin
    s0_nx     = '0;
    s0_d      = {in_abscissa[31], in_abscissa} - {center_r[31], center_r};
    s0_nx.vld = start && !busy && rst_n;
    s0_nx.a   = {{31{s0_d[32]}}, s0_d};
  end
  always_ff @(posedge clk) begin
    pipe_r[1] <= s0_nx;
  end

  // Stage 1: range check and divider setup
  st_t s1_nx;
  always_comb begin
    s1_nx     = pipe_r[1];
    s1_nx.vld = pipe_r[1].vld && rst_n;
    s1_nx.act = !pipe_r[1].a[32] && ({5'b0, pipe_r[1].a[31:0]} < {wdv[30:0], 6'b0});
    s1_nx.a   = {32'b0, pipe_r[1].a[31:0]};
    s1_nx.c   = {38'b0, pipe_r[1].a[31:6]};
    s1_nx.b   = '0;
  end
  always_ff @(posedge clk) begin
    pipe_r[2] <= s1_nx;
  end

  // Scaled offset z = d / width, 38 quotient bits
  for (genvar i = 0; i < ZSt; i++) begin : g_zdiv
    st_t         nx;
    logic [63:0] nv;
    logic [64:0] ds;
    always_comb begin
      nx     = pipe_r[OZdiv+i];
      nx.vld = nx.vld && rst_n;
      nv     = {nx.a[31:0], 32'b0};
      for (int m = 0; m < 2; m++) begin
        ds   = div_step(nx.c, nv[37-(2*i+m)], wdv);
        nx.c = ds[63:0];
        nx.b = {nx.b[62:0], ds[64]};
      end
    end
    always_ff @(posedge clk) begin
      pipe_r[OZdiv+i+1] <= nx;
    end
  end

  // Series setup: w = z/64 in Q.60
  st_t sw_nx;
  always_comb begin
    sw_nx     = pipe_r[OW];
    sw_nx.vld = pipe_r[OW].vld && rst_n;
    sw_nx.c   = {pipe_r[OW].b[41:0], 22'b0};
    sw_nx.a   = QOne;
    sw_nx.b   = QOne;
  end
  always_ff @(posedge clk) begin
    pipe_r[OW+1] <= sw_nx;
  end

  // Taylor series of e^-w: a holds the sum, b the term.
  // Each divide stage takes one byte of the dividend; the byte quotient
  // comes from a reciprocal multiplication, exact for these operand sizes.
  for (genvar t = 0; t < NTerm; t++) begin : g_term
    localparam logic [63:0] Recip = ((64'd1 << 32) + 64'(t)) / 64'(t + 1);
    for (genvar j = 0; j < TermSt; j++) begin : g_st
      localparam int unsigned S = OSer + t * TermSt + j;
      st_t         nx;
      logic [12:0] dv;
      logic [45:0] mq;
      logic [7:0]  qd;
      logic [12:0] rm;
      always_comb begin
        nx     = pipe_r[S];
        nx.vld = nx.vld && rst_n;
        dv     = '0;
        mq     = '0;
        qd     = '0;
        rm     = '0;
        if (j == 0) begin
          nx.pp = mul_pp(nx.b, nx.c);
        end else if (j == 1) begin
          nx.e = qsel(nx.pp);
          nx.f = '0;
          nx.b = '0;
        end else begin
          dv   = {nx.f[4:0], nx.e[63-8*(j-2) -: 8]};
          mq   = {33'b0, dv} * {13'b0, Recip[32:0]};
          qd   = mq[39:32];
          rm   = dv - {5'b0, qd} * 13'(t + 1);
          nx.f = {59'b0, rm[4:0]};
          nx.b = {nx.b[55:0], qd};
          if (j == TermSt - 1) begin
            nx.a = (t % 2 == 0) ? nx.a - nx.b : nx.a + nx.b;
          end
        end
      end
      always_ff @(posedge clk) begin
        pipe_r[S+1] <= nx;
      end
    end
  end

  // Six squarings give e^-z
  for (genvar i = 0; i < 2 * NSq; i++) begin : g_sq
    st_t nx;
    always_comb begin
      nx     = pipe_r[OSq+i];
      nx.vld = nx.vld && rst_n;
      if (i % 2 == 0) nx.pp = mul_pp(nx.a, nx.a);
      else            nx.a  = qsel(nx.pp);
    end
    always_ff @(posedge clk) begin
      pipe_r[OSq+i+1] <= nx;
    end
  end

  // u = 1 - e^-z; c holds the power, b the base, e the root chain
  st_t su_nx;
  always_comb begin
    su_nx     = pipe_r[OU];
    su_nx.vld = pipe_r[OU].vld && rst_n;
    su_nx.b   = QOne - pipe_r[OU].a;
    su_nx.e   = QOne - pipe_r[OU].a;
    su_nx.uz  = (pipe_r[OU].a == QOne);
    su_nx.c   = QOne;
  end
  always_ff @(posedge clk) begin
    pipe_r[OU+1] <= su_nx;
  end

  // Integer part of the exponent by square and multiply
  for (genvar i = 0; i < 2 * PBits; i++) begin : g_pow
    st_t nx;
    always_comb begin
      nx     = pipe_r[OPow+i];
      nx.vld = nx.vld && rst_n;
      if (i % 2 == 0) begin
        nx.pp = mul_pp(nx.c, nx.b);
        nx.pq = mul_pp(nx.b, nx.b);
      end else begin
        if (shv[ShapeFrac+i/2]) nx.c = qsel(nx.pp);
        nx.b = qsel(nx.pq);
      end
    end
    always_ff @(posedge clk) begin
      pipe_r[OPow+i+1] <= nx;
    end
  end

  // Fraction bits of the exponent by repeated square roots
  for (genvar g = 0; g < ShapeFrac; g++) begin : g_root
    for (genvar i = 0; i < RtGrp; i++) begin : g_st
      localparam int unsigned S = ORt + g * RtGrp + i;
      st_t          nx;
      logic [127:0] nv;
      logic [127:0] sq;
      always_comb begin
        nx     = pipe_r[S];
        nx.vld = nx.vld && rst_n;
        nv     = {4'b0, nx.e, 60'b0};
        sq     = '0;
        if (i < RootSt) begin
          if (i == 0) begin
            nx.f = '0;
            nx.b = '0;
          end
          for (int m = 0; m < 4; m++) begin
            sq   = sqrt_step(nx.f, nx.b, nv[127-2*(4*i+m) -: 2]);
            nx.f = sq[127:64];
            nx.b = sq[63:0];
          end
        end else if (i == RootSt) begin
          nx.e  = nx.f;
          nx.pp = mul_pp(nx.c, nx.f);
        end else begin
          if (shv[ShapeFrac-1-g]) nx.c = qsel(nx.pp);
        end
      end
      always_ff @(posedge clk) begin
        pipe_r[S+1] <= nx;
      end
    end
  end

  // G = e^-z * u^s
  for (genvar i = 0; i < 2; i++) begin : g_gm
    st_t nx;
    always_comb begin
      nx     = pipe_r[OG+i];
      nx.vld = nx.vld && rst_n;
      if (i == 0) nx.pp = mul_pp(nx.a, nx.uz ? 64'b0 : nx.c);
      else        nx.a  = qsel(nx.pp);
    end
    always_ff @(posedge clk) begin
      pipe_r[OG+i+1] <= nx;
    end
  end

  // |area| * (s + 1)
  st_t         sa_nx;
  logic [31:0] amag;
  logic [56:0] amul;
  always_comb begin
    sa_nx     = pipe_r[OAm];
    sa_nx.vld = pipe_r[OAm].vld && rst_n;
    amag      = area_r[31] ? (~area_r + 32'd1) : area_r;
    amul      = {25'b0, amag} * {32'b0, {1'b0, shv} + 25'h01_0000};
    sa_nx.b   = {7'b0, amul};
  end
  always_ff @(posedge clk) begin
    pipe_r[OAm+1] <= sa_nx;
  end

  // Scale by G and align to the output format
  for (genvar i = 0; i < 2; i++) begin : g_pk
    st_t          nx;
    logic [191:0] pw;
    always_comb begin
      nx     = pipe_r[OPk+i];
      nx.vld = nx.vld && rst_n;
      pw     = '0;
      if (i == 0) begin
        nx.pp = mul_pp(nx.b, nx.a);
      end else begin
        pw   = {64'b0, pp_sum(nx.pp)} >> OutShift;
        nx.e = pw[63:0];
        nx.f = '0;
        nx.b = '0;
      end
    end
    always_ff @(posedge clk) begin
      pipe_r[OPk+i+1] <= nx;
    end
  end

  // Division of the peak term by the width
  for (genvar i = 0; i < WSt; i++) begin : g_wdiv
    st_t         nx;
    logic [64:0] ds;
    always_comb begin
      nx     = pipe_r[OWd+i];
      nx.vld = nx.vld && rst_n;
      for (int m = 0; m < 2; m++) begin
        ds   = div_step(nx.f, nx.e[63-(2*i+m)], wdv);
        nx.f = ds[63:0];
        nx.b = {nx.b[62:0], ds[64]};
      end
    end
    always_ff @(posedge clk) begin
      pipe_r[OWd+i+1] <= nx;
    end
  end

  // Cap, sign, background and saturation
  logic [33:0]        qc;
  logic signed [35:0] tval;
  logic signed [35:0] total;
  logic               sat_nxt;
  logic signed [31:0] val_nxt;
  always_comb begin
    qc    = (pipe_r[OFin].b > {30'b0, TermCap}) ? TermCap : pipe_r[OFin].b[33:0];
    tval  = area_r[31] ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
    total = {{4{bkgnd_r[31]}}, bkgnd_r} + (pipe_r[OFin].act ? tval : 36'sd0);
    priority if (total > 36'sh0_7FFF_FFFF) begin
      val_nxt = 32'sh7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (total < -36'sh0_8000_0000) begin
      val_nxt = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      val_nxt = total[31:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pipe_r[OFin].vld;
    end
    out_peak_value_r <= val_nxt;
    out_saturated_r  <= sat_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_peak_value = out_peak_value_r;
  assign out_saturated  = out_saturated_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, OFin + 1))
    else $error("result word without a matching input word");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_saturated) |->
      (out_peak_value == 32'sh7FFF_FFFF || out_peak_value == 32'sh8000_0000))
    else $error("saturated word not at a range limit");

  a_idle_bkgnd: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe_r[OFin].vld && !pipe_r[OFin].act) |=>
      (out_peak_value == $past(bkgnd_r) && !out_saturated))
    else $error("word outside the peak does not return the background");

endmodule

// ===== dv/pulse_peak_power_term_eval_unit_test.sv =====
// ----------------------------------------------------------------------------
// pulse_peak_power_term_eval_unit_test
// Self-checking testbench of the pulse peak evaluator. A scoreboard predicts
// each result from its own copy of the registers. Directed words cover onset,
// range edges and saturation. Random words are aimed mostly inside the peak
// region, under several register settings with random input gaps.
// ----------------------------------------------------------------------------
module pulse_peak_power_term_eval_unit_test;
  import pppt_pkg::*;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned Latency    = 576;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseWords = 106;

  typedef struct {
    logic [31:0] value;
    logic        sat;
  } peak_word_t;

  class peak_scoreboard;
    longint     area, center, bgnd;
    bit [63:0]  width, shape;
    peak_word_t pending[$];
    int         errors;

    function new();
      area   = longint'(1) << FracBits;
      center = 0;
      width  = 64'd1 << FracBits;
      shape  = 64'd1 << ShapeFrac;
      bgnd   = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_AREA:   area   = longint'($signed(val));
        REG_CENTER: center = longint'($signed(val));
        REG_WIDTH:  width  = {33'b0, val[30:0]};
        REG_SHAPE:  shape  = {40'b0, val[23:0]};
        REG_BKGND:  bgnd   = longint'($signed(val));
        default: ;
      endcase
    endfunction

    function bit [63:0] fmul(bit [63:0] a, bit [63:0] b);
      bit [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[QBits+63:QBits];
    endfunction

    function bit [63:0] froot(bit [63:0] r);
      bit [127:0] v;
      bit [63:0]  res, rem, trial;
      v   = {64'b0, r} << QBits;
      res = 0;
      rem = 0;
      for (int i = 0; i < 64; i++) begin
        rem   = (rem << 2) | v[127-2*i -: 2];
        trial = (res << 2) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          res = (res << 1) | 64'd1;
        end else begin
          res = res << 1;
        end
      end
      return res;
    endfunction

    function bit [63:0] decay(bit [63:0] zi, bit [63:0] zf);
      bit [63:0] w, sum, term;
      w    = (zi << 54) + (zf << 22);
      sum  = QOne;
      term = QOne;
      for (int n = 1; n <= 20; n++) begin
        term = fmul(term, w) / n;
        if (n % 2) sum = sum - term;
        else sum = sum + term;
      end
      for (int n = 0; n < 6; n++) sum = fmul(sum, sum);
      return sum;
    endfunction

    function bit [63:0] rise_pow(bit [63:0] u, bit [63:0] sh);
      bit [63:0] p, base, si, r;
      if (u == 0) return 0;
      p    = QOne;
      base = u;
      si   = sh >> ShapeFrac;
      r    = u;
      while (si != 0) begin
        if (si[0]) p = fmul(p, base);
        base = fmul(base, base);
        si   = si >> 1;
      end
      for (int k = 1; k <= ShapeFrac; k++) begin
        r = froot(r);
        if (sh[ShapeFrac-k]) p = fmul(p, r);
      end
      return p;
    endfunction

    function void note_input(logic [31:0] x);
      longint     d, total;
      bit [63:0]  wd, sh, zi, zf, e, g, amag, q;
      bit [127:0] prod;
      peak_word_t exp_word;
      d     = longint'($signed(x)) - center;
      total = bgnd;
      if (d >= 0) begin
        wd = (width != 0) ? width : 64'd1;
        sh = (shape != 0) ? shape : 64'd1;
        zi = 64'(d) / wd;
        if (zi < 64) begin
          zf   = ((64'(d) - zi * wd) << 32) / wd;
          e    = decay(zi, zf);
          g    = fmul(e, rise_pow(QOne - e, sh));
          amag = (area < 0) ? 64'(-area) : 64'(area);
          prod = {64'b0, amag * (sh + (64'd1 << ShapeFrac))} * {64'b0, g};
          q    = 64'(prod >> (76 - FracBits)) / wd;
          if (q > 64'(TermCap)) q = 64'(TermCap);
          total = (area < 0) ? total - longint'(q) : total + longint'(q);
        end
      end
      exp_word.sat = 1'b0;
      if (total > 64'sd2147483647) begin
        total = 64'sd2147483647;
        exp_word.sat = 1'b1;
      end else if (total < -64'sd2147483648) begin
        total = -64'sd2147483648;
        exp_word.sat = 1'b1;
      end
      exp_word.value = total[31:0];
      pending.push_back(exp_word);
    endfunction

    function void check(logic [31:0] value, logic sat);
      peak_word_t exp_word;
      if (pending.size() == 0) begin
        $error("unexpected result word value %h", value);
        errors++;
        return;
      end
      exp_word = pending.pop_front();
      if (value !== exp_word.value) begin
        $error("peak_value expected %h actual %h", exp_word.value, value);
        errors++;
      end
      if (sat !== exp_word.sat) begin
        $error("saturated expected %b actual %b", exp_word.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_abscissa = '0;
  logic               out_strobe;
  logic signed [31:0] out_peak_value;
  logic               out_saturated;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  peak_scoreboard sb = new();
  int unsigned    stall_cycles = 0;
  bit             gaps_on;

  pulse_peak_power_term_eval_unit #(.FRAC_BITS(FracBits)) u_top (
    .clk, .rst_n, .start, .busy, .in_abscissa, .out_strobe, .out_peak_value,
    .out_saturated, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_input(in_abscissa);
    end
    if (rst_n && out_strobe) begin
      sb.check(out_peak_value, out_saturated);
    end
    if (rst_n && psel && penable && pwrite && pready) begin
      sb.write_reg(paddr[4:2], pwdata);
    end
    if (rst_n && ((start && !busy) || out_strobe || (psel && penable && pwrite && pready))) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("FAIL pulse_peak_power_term_eval_unit");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  task automatic send_word(logic [31:0] x);
    int unsigned gap;
    @(negedge clk);
    start       = 1'b1;
    in_abscissa = x;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    forever begin
      @(posedge clk);
      if (pready) break;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic load_setting(logic [31:0] a, logic [31:0] c, logic [31:0] w,
                              logic [31:0] s, logic [31:0] b);
    drain();
    write_reg(REG_AREA, a);
    write_reg(REG_CENTER, c);
    write_reg(REG_WIDTH, w);
    write_reg(REG_SHAPE, s);
    write_reg(REG_BKGND, b);
  endtask

  function automatic logic [31:0] pick_abscissa();
    longint    x;
    bit [63:0] span, off;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom;
    if (r < 30) begin
      x = sb.center - longint'($urandom_range(1, 1 << 20));
    end else begin
      span = ((sb.width != 0) ? sb.width : 64'd1) * 64;
      off  = {$urandom, $urandom} % span;
      x    = sb.center + longint'(off);
    end
    if (x > 64'sd2147483647 || x < -64'sd2147483648) return $urandom;
    return x[31:0];
  endfunction

  initial begin
    logic [31:0] directed[$];
    gaps_on = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    load_setting(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h01_0000, 32'h0);
    directed = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                 32'h0001_0000, 32'h0000_8000, 32'h0003_0000, 32'h003F_FFFF,
                 32'h0040_0000, 32'h0040_0001, 32'h0000_0010, 32'h0010_0000};
    foreach (directed[i]) send_word(directed[i]);

    load_setting(32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1, 32'h7FFF_FFFF);
    directed = '{32'h0, 32'h1, 32'h2, 32'h5, 32'h3F, 32'h40};
    foreach (directed[i]) send_word(directed[i]);

    load_setting(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFF_FFFF,
                 32'h8000_0000);
    directed = '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'hC000_0000};
    foreach (directed[i]) send_word(directed[i]);

    load_setting(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h1234_5678);
    send_word(32'h7FFF_FFFF);
    send_word(32'h7FFF_FFFE);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: load_setting(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h01_0000, 32'h0);
        1: load_setting(32'h7FFF_FFFF, $urandom, 32'h1, 32'h1, 32'h7FFF_FFFF);
        2: load_setting(32'h8000_0000, $urandom, 32'h7FFF_FFFF, 32'hFF_FFFF,
                        32'h8000_0000);
        3: load_setting($urandom, $urandom, $urandom_range(32'h1_0000, 32'h10_0000),
                        $urandom_range(32'h8000, 32'h4_0000), $urandom);
        4: load_setting($urandom, $urandom, 32'h0, 32'h0, $urandom);
        default: load_setting($urandom, $urandom, $urandom_range(1, 32'h7FFF_FFFF),
                              $urandom_range(1, 32'hFF_FFFF), $urandom);
      endcase
      gaps_on = ph[0];
      for (int i = 0; i < PhaseWords; i++) begin
        if (i % 40 == 0) gaps_on = $urandom_range(0, 2) != 0;
        send_word(pick_abscissa());
      end
    end

    drain();
    repeat (Latency + 20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS pulse_peak_power_term_eval_unit");
    end else begin
      $display("FAIL pulse_peak_power_term_eval_unit");
    end
    $finish;
  end

endmodule
